### hdl/bdq_pkg.sv
package bdq_pkg;

  localparam int unsigned REQ_W   = 3;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned CNT_W   = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_REMOVE     = 3'd4,
    REQ_FIND       = 3'd5,
    REQ_CLEAR      = 3'd6
  } req_type_e;

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch incoming request
    logic compare;    // register per-slot match vector
    logic scan_step;  // advance scan index
    logic apply;      // update store and response register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_search;  // remove value or find
    logic hit;        // match at current scan index
    logic last;       // scan index at last slot
  } ctrl_sts_t;

endpackage

### hdl/bdq_req_if.sv
interface bdq_req_if;
  import bdq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [REQ_W-1:0]          req_type;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);

endinterface

### hdl/bdq_rsp_if.sv
interface bdq_rsp_if;
  import bdq_pkg::*;

  logic             valid;
  logic             ready;
  logic             ok;
  logic             found;
  logic [POS_W-1:0] position;
  logic [CNT_W-1:0] count;

  modport source (output valid, output ok, output found, output position, output count,
                  input ready);
  modport sink   (input valid, input ok, input found, input position, input count,
                  output ready);

endinterface

### hdl/bounded_deque_with_value_removal_unit.sv
// Sequence: every request is captured, compared against all slots and applied; find and
//   remove value scan in between, stopping at the first match or the last slot.
// Throughput: one request at a time, taken once the last is applied; apply waits while an
//   older response is held. The slot-by-slot scan sets the search time.
// Reset: rst_ni is asynchronous, active low; it empties the deque and drops any response.
module bounded_deque_with_value_removal_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bdq_req_if.sink   req_i,
  bdq_rsp_if.source rsp_o
);
  import bdq_pkg::*;

  // Controller sequences each request: capture -> compare all slots -> scan the match
  // vector (searches only) -> apply. The datapath holds the element store as a row of
  // registers that shift on push front, pop front and remove, plus the response register.
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  bdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Response register sits in the datapath, so a new request can be taken
  // while the previous response waits on rsp_o.ready.
  bdq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .req_type_i (req_i.req_type),
    .value_i    (req_i.value),
    .ok_o       (rsp_o.ok),
    .found_o    (rsp_o.found),
    .position_o (rsp_o.position),
    .count_o    (rsp_o.count)
  );

endmodule

### hdl/bdq_datapath.sv
module bdq_datapath #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  bdq_pkg::ctrl_cmd_t                 cmd_i,
  output bdq_pkg::ctrl_sts_t                 sts_o,
  input  logic [bdq_pkg::REQ_W-1:0]          req_type_i,
  input  logic signed [bdq_pkg::VALUE_W-1:0] value_i,
  output logic                               ok_o,
  output logic                               found_o,
  output logic [bdq_pkg::POS_W-1:0]          position_o,
  output logic [bdq_pkg::CNT_W-1:0]          count_o
);
  import bdq_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);
  localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

  logic [REQ_W-1:0]          req_q;
  logic signed [VALUE_W-1:0] val_q;
  logic signed [VALUE_W-1:0] store_q [CAPACITY];
  logic signed [VALUE_W-1:0] store_d [CAPACITY];
  logic [CW-1:0]             count_q, count_d;
  logic [CAPACITY-1:0]       match_q, match_d;
  logic [IW-1:0]             idx_q;

  logic             ok_q, ok_d;
  logic             found_q, found_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] cnt_q;

  logic          hit_now, full, empty, rmv;
  logic [IW-1:0] rmv_at;

  assign hit_now = match_q[idx_q];
  assign full    = (count_q == CAP_CNT);
  assign empty   = (count_q == '0);

  assign sts_o.is_search = (req_q == REQ_REMOVE) || (req_q == REQ_FIND);
  assign sts_o.hit       = hit_now;
  assign sts_o.last      = (idx_q == LAST_IDX);

  // one comparator per slot, masked by occupancy
  always_comb begin
    for (int j = 0; j < CAPACITY; j++) begin
      match_d[j] = (store_q[j] == val_q) && (CW'(j) < count_q);
    end
  end

  always_comb begin
    store_d = store_q;
    count_d = count_q;
    ok_d    = 1'b0;
    found_d = 1'b0;
    pos_d   = '0;
    rmv     = 1'b0;
    rmv_at  = '0;
    unique case (req_q)
      REQ_PUSH_FRONT: begin
        if (!full) begin
          for (int j = CAPACITY - 1; j > 0; j--) begin
            store_d[j] = store_q[j-1];
          end
          store_d[0] = val_q;
          count_d    = count_q + 1'b1;
          ok_d       = 1'b1;
        end
      end
      REQ_PUSH_BACK: begin
        if (!full) begin
          for (int j = 0; j < CAPACITY; j++) begin
            if (CW'(j) == count_q) store_d[j] = val_q;
          end
          count_d = count_q + 1'b1;
          ok_d    = 1'b1;
        end
      end
      REQ_POP_FRONT: begin
        if (!empty) begin
          rmv  = 1'b1;
          ok_d = 1'b1;
        end
      end
      REQ_POP_BACK: begin
        if (!empty) begin
          count_d = count_q - 1'b1;
          ok_d    = 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (hit_now) begin
          rmv     = 1'b1;
          rmv_at  = idx_q;
          ok_d    = 1'b1;
          found_d = 1'b1;
          pos_d   = POS_W'(idx_q);
        end
      end
      REQ_FIND: begin
        if (hit_now) begin
          ok_d    = 1'b1;
          found_d = 1'b1;
          pos_d   = POS_W'(idx_q);
        end
      end
      REQ_CLEAR: begin
        count_d = '0;
        ok_d    = 1'b1;
      end
      default: ;
    endcase
    // close the gap at rmv_at
    if (rmv) begin
      for (int j = 0; j < CAPACITY - 1; j++) begin
        if (IW'(j) >= rmv_at) store_d[j] = store_q[j+1];
      end
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      if (cmd_i.load) begin
        idx_q <= '0;
      end else if (cmd_i.scan_step) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.apply) count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_type_i;
      val_q <= value_i;
    end
    if (cmd_i.compare) match_q <= match_d;
    if (cmd_i.apply) begin
      store_q <= store_d;
      ok_q    <= ok_d;
      found_q <= found_d;
      pos_q   <= pos_d;
      cnt_q   <= CNT_W'(count_d);
    end
  end

  assign ok_o       = ok_q;
  assign found_o    = found_q;
  assign position_o = pos_q;
  assign count_o    = cnt_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_CNT)
    else $error("element count above capacity");

  a_scan_stops_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_step |-> !hit_now)
    else $error("scan advanced past a match");

endmodule

### hdl/bdq_ctrl.sv
module bdq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  output logic               rsp_valid_o,
  input  logic               rsp_ready_i,
  output bdq_pkg::ctrl_cmd_t cmd_o,
  input  bdq_pkg::ctrl_sts_t sts_i
);
  import bdq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_SCAN,
    ST_APPLY
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  assign req_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = out_valid_q;

  assign cmd_o.load      = (state_q == ST_IDLE) && req_valid_i;
  assign cmd_o.compare   = (state_q == ST_CMP);
  assign cmd_o.scan_step = (state_q == ST_SCAN) && !sts_i.hit && !sts_i.last;
  assign cmd_o.apply     = (state_q == ST_APPLY) && (!out_valid_q || rsp_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.apply) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (req_valid_i) state_q <= ST_CMP;
        end
        ST_CMP: begin
          state_q <= sts_i.is_search ? ST_SCAN : ST_APPLY;
        end
        ST_SCAN: begin
          if (sts_i.hit || sts_i.last) state_q <= ST_APPLY;
        end
        ST_APPLY: begin
          if (cmd_o.apply) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> !req_ready_o)
    else $error("new request taken while one is in flight");

  a_apply_gives_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.apply |=> rsp_valid_o)
    else $error("committed result not presented");

  a_scan_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) && sts_i.last |=> state_q != ST_SCAN)
    else $error("scan ran past last slot");

endmodule

### tb/bounded_deque_with_value_removal_unit_tb.sv
`timescale 1ns / 100ps

module bounded_deque_with_value_removal_unit_tb;
  import bdq_pkg::*;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned RAND_REQS = 1650;
  localparam int unsigned MAX_SHOWN = 50;  // mismatch lines printed, all are counted

  // 3-bit request code with no meaning; the block must answer it without effect
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 3'd7;

  typedef struct packed {
    logic             ok;
    logic             found;
    logic [POS_W-1:0] position;
    logic [CNT_W-1:0] count;
  } rsp_t;

  // one line of the directed plan; reps > 1 repeats it with value + k
  typedef struct {
    logic [REQ_W-1:0]   rt;
    logic [VALUE_W-1:0] v;
    int unsigned        reps;
    bit                 pinned;  // response typed in below, not taken from the shadow list
    rsp_t               want;
  } plan_item_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bdq_req_if req_if ();
  bdq_rsp_if rsp_if ();

  bounded_deque_with_value_removal_unit #(
    .CAPACITY (DEPTH)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the deque: slot 0 of the list is the front.
  // ---------------------------------------------------------------------------
  logic [VALUE_W-1:0] shadow[$];
  rsp_t               owed_rsp[$];   // responses still to come, oldest first

  // pinned response travels with the request it belongs to
  bit   pin_on;
  rsp_t pin_rsp;

  bit          calm;        // no idling on either side while set
  int unsigned bad_count;
  int unsigned n_req, n_rsp, n_hit, n_full, n_empty, n_unknown;

  // Apply one request to the shadow list and return the response it must give.
  function automatic rsp_t deque_apply(logic [REQ_W-1:0] rt, logic [VALUE_W-1:0] v);
    rsp_t r;
    int   hit;
    r   = '0;
    hit = -1;
    // first match from the front; only live slots are looked at
    foreach (shadow[i]) begin
      if (hit < 0 && shadow[i] == v) hit = i;
    end
    case (rt)
      REQ_PUSH_FRONT: begin
        if (shadow.size() < DEPTH) begin
          shadow.push_front(v);
          r.ok = 1'b1;
        end
      end
      REQ_PUSH_BACK: begin
        if (shadow.size() < DEPTH) begin
          shadow.push_back(v);
          r.ok = 1'b1;
        end
      end
      REQ_POP_FRONT: begin
        if (shadow.size() > 0) begin
          void'(shadow.pop_front());
          r.ok = 1'b1;
        end
      end
      REQ_POP_BACK: begin
        if (shadow.size() > 0) begin
          void'(shadow.pop_back());
          r.ok = 1'b1;
        end
      end
      REQ_REMOVE, REQ_FIND: begin
        // a miss leaves ok, found and position all at zero
        if (hit >= 0) begin
          r.ok       = 1'b1;
          r.found    = 1'b1;
          r.position = POS_W'(hit);
          if (rt == REQ_REMOVE) shadow.delete(hit);
        end
      end
      REQ_CLEAR: begin
        shadow.delete();
        r.ok = 1'b1;
      end
      default: ;  // unknown code: nothing changes
    endcase
    r.count = CNT_W'(shadow.size());
    return r;
  endfunction

  task automatic report_bad(input string what);
    if (bad_count < MAX_SHOWN) $display("%0t ns  MISMATCH  %s", $time, what);
    bad_count++;
  endtask

  // Both handshakes are observed here, at the rising edge, in one process.
  always @(posedge clk_i) begin
    rsp_t want, got;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        want = deque_apply(req_if.req_type, req_if.value);
        if (pin_on) want = pin_rsp;
        owed_rsp.push_back(want);
        n_req++;
        if (want.found) n_hit++;
        if (!want.ok && req_if.req_type inside {REQ_PUSH_FRONT, REQ_PUSH_BACK}) n_full++;
        if (!want.ok && req_if.req_type inside {REQ_POP_FRONT, REQ_POP_BACK}) n_empty++;
        if (req_if.req_type == REQ_UNKNOWN) n_unknown++;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        got = '{rsp_if.ok, rsp_if.found, rsp_if.position, rsp_if.count};
        n_rsp++;
        if (owed_rsp.size() == 0) begin
          report_bad($sformatf("response %0d arrived with no request waiting", n_rsp));
        end else begin
          want = owed_rsp.pop_front();
          if (got.ok !== want.ok)
            report_bad($sformatf("rsp %0d ok: got %b want %b", n_rsp, got.ok, want.ok));
          if (got.found !== want.found)
            report_bad($sformatf("rsp %0d found: got %b want %b",
                                 n_rsp, got.found, want.found));
          if (got.position !== want.position)
            report_bad($sformatf("rsp %0d position: got %0d want %0d",
                                 n_rsp, got.position, want.position));
          if (got.count !== want.count)
            report_bad($sformatf("rsp %0d count: got %0d want %0d",
                                 n_rsp, got.count, want.count));
        end
      end
    end
  end

  // Gap length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 45) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Response side: ready drops for random stretches, changed at the falling edge.
  initial rsp_if.ready = 1'b0;

  always @(negedge clk_i) begin
    int unsigned stall_left;
    if (stall_left > 0) begin
      rsp_if.ready <= 1'b0;
      stall_left--;
    end else begin
      rsp_if.ready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // Send one request. Called at a falling edge, returns at a falling edge.
  task automatic send_req(input logic [REQ_W-1:0] rt, input logic [VALUE_W-1:0] v,
                          input bit pinned, input rsp_t want);
    int unsigned idle;
    idle = pick_gap();
    if (idle > 0) begin
      req_if.valid <= 1'b0;
      repeat (idle) @(negedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= rt;
    req_if.value    <= v;
    pin_on          <= pinned;
    pin_rsp         <= want;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  // Operand choice: held values to hit deep positions, a small pool to make
  // duplicates, and fully random words for the rest.
  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30 && shadow.size() > 0) return shadow[$urandom_range(0, shadow.size() - 1)];
    if (r < 75) begin
      case ($urandom_range(0, 7))
        0:       return 32'h0000_0000;
        1:       return 32'hFFFF_FFFF;
        2:       return 32'h8000_0000;
        3:       return 32'h7FFF_FFFF;
        4:       return 32'h0000_0001;
        5:       return 32'hA5A5_5A5A;
        6:       return 32'h1234_5678;
        default: return 32'hFFFF_FFFE;
      endcase
    end
    return $urandom();
  endfunction

  function automatic plan_item_t plan_item(logic [REQ_W-1:0] rt, logic [VALUE_W-1:0] v,
                                           int unsigned reps, bit pinned, logic ok,
                                           logic fnd, int unsigned pos, int unsigned cnt);
    plan_item_t p;
    p.rt     = rt;
    p.v      = v;
    p.reps   = reps;
    p.pinned = pinned;
    p.want   = '{ok, fnd, POS_W'(pos), CNT_W'(cnt)};
    return p;
  endfunction

  initial begin : stimulus
    plan_item_t  plan[$];
    plan_item_t  p;
    int unsigned r;
    bit          fill_lean;
    logic [REQ_W-1:0] rt;

    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.req_type = REQ_PUSH_FRONT;
    req_if.value    = '0;
    pin_on          = 1'b0;
    pin_rsp         = '0;
    calm            = 1'b0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed plan.      request         value          reps pin ok fnd pos cnt
    // Empty store right after reset: pops, searches and the unknown code all fail.
    plan.push_back(plan_item(REQ_POP_FRONT,  32'h0,          1, 1, 0, 0, 0, 0));
    plan.push_back(plan_item(REQ_POP_BACK,   32'h0,          1, 1, 0, 0, 0, 0));
    plan.push_back(plan_item(REQ_REMOVE,     32'h8000_0000,  1, 1, 0, 0, 0, 0));
    plan.push_back(plan_item(REQ_FIND,       32'h7FFF_FFFF,  1, 1, 0, 0, 0, 0));
    plan.push_back(plan_item(REQ_UNKNOWN,    32'hFFFF_FFFF,  1, 1, 0, 0, 0, 0));
    // Extremes of the value field at both ends.
    plan.push_back(plan_item(REQ_PUSH_FRONT, 32'h8000_0000,  1, 1, 1, 0, 0, 1));
    plan.push_back(plan_item(REQ_PUSH_BACK,  32'h7FFF_FFFF,  1, 1, 1, 0, 0, 2));
    plan.push_back(plan_item(REQ_PUSH_FRONT, 32'h0,          1, 0, 0, 0, 0, 0));
    plan.push_back(plan_item(REQ_PUSH_BACK,  32'hFFFF_FFFF,  1, 0, 0, 0, 0, 0));
    // Search hits, a remove at the front, a remove with no match.
    plan.push_back(plan_item(REQ_FIND,       32'h7FFF_FFFF,  1, 0, 0, 0, 0, 0));
    plan.push_back(plan_item(REQ_REMOVE,     32'h0,          1, 0, 0, 0, 0, 0));
    plan.push_back(plan_item(REQ_REMOVE,     32'h55AA_55AA,  1, 0, 0, 0, 0, 0));
    plan.push_back(plan_item(REQ_POP_FRONT,  32'h0,          1, 0, 0, 0, 0, 0));
    plan.push_back(plan_item(REQ_POP_BACK,   32'h0,          1, 0, 0, 0, 0, 0));
    // Fill to capacity, then both inserts must be refused with the count held.
    plan.push_back(plan_item(REQ_PUSH_BACK,  32'hA5A5_0000, 15, 0, 0, 0, 0, 0));
    plan.push_back(plan_item(REQ_PUSH_FRONT, 32'h1111_1111,  1, 1, 0, 0, 0, 16));
    plan.push_back(plan_item(REQ_PUSH_BACK,  32'h2222_2222,  1, 1, 0, 0, 0, 16));
    // Match in the last slot, then clear a full store.
    plan.push_back(plan_item(REQ_FIND,       32'hA5A5_000E,  1, 0, 0, 0, 0, 0));
    plan.push_back(plan_item(REQ_CLEAR,      32'h0,          1, 1, 1, 0, 0, 0));

    foreach (plan[i]) begin
      p = plan[i];
      for (int unsigned k = 0; k < p.reps; k++) send_req(p.rt, p.v + k, p.pinned, p.want);
    end

    // Random part. Every 150 requests the mix leans toward filling or draining,
    // and now and then a stretch runs with no idling at all.
    for (int unsigned n = 0; n < RAND_REQS; n++) begin
      if (n % 150 == 0) begin
        calm      = ($urandom_range(0, 3) == 0);
        fill_lean = $urandom_range(0, 1);
      end
      r = $urandom_range(0, 99);
      if (r < 3)                        rt = REQ_UNKNOWN;
      else if (r < 6)                   rt = REQ_CLEAR;
      else if (r < (fill_lean ? 31 : 21)) rt = REQ_PUSH_FRONT;
      else if (r < (fill_lean ? 56 : 36)) rt = REQ_PUSH_BACK;
      else if (r < (fill_lean ? 63 : 52)) rt = REQ_POP_FRONT;
      else if (r < (fill_lean ? 70 : 68)) rt = REQ_POP_BACK;
      else if (r < 84)                  rt = REQ_REMOVE;
      else                              rt = REQ_FIND;
      send_req(rt, pick_value(), 1'b0, '0);
    end
    req_if.valid <= 1'b0;
    calm = 1'b1;

    // Drain, then keep the clock running for anything stray.
    while (owed_rsp.size() != 0) @(posedge clk_i);
    repeat (DEPTH + 8) @(posedge clk_i);

    $display("Covered %0d requests, %0d responses: %0d search hits, %0d refused on full,",
             n_req, n_rsp, n_hit, n_full);
    $display("  %0d pops on empty, %0d unknown codes; %0d mismatches.",
             n_empty, n_unknown, bad_count);
    if (bad_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: set at several times the slowest legal run
  // (full scans, longest gaps and stalls on every request).
  initial begin
    #4000000;
    $display("Timeout with %0d responses still owed.", owed_rsp.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
